### design/hre_pkg.sv
// Package for the hex region enumerator: control word and status types,
// microcode field codes, program addresses and the hex direction table.
// No dependencies.
package hre_pkg;

   localparam int MAX_RADIUS = 4;
   localparam int RAD_W      = 3;    // radius, ring index, step and direction counters
   localparam int OFS_W      = 5;    // signed offsets inside a range, -4 .. 4
   localparam int IN_W       = 15;   // center coordinate width
   localparam int CW         = 16;   // emitted coordinate width
   localparam int PC_W       = 4;    // microprogram address width

   // Region kinds on req_action.
   localparam logic [1:0] ACT_RING   = 2'd0;
   localparam logic [1:0] ACT_RANGE  = 2'd1;
   localparam logic [1:0] ACT_SPIRAL = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;   // taken and dropped, no cells

   // Coordinate datapath operations.
   localparam logic [2:0] QR_HOLD  = 3'd0;
   localparam logic [2:0] QR_RING  = 3'd1;  // q = cq - k, r = cr + k, clear walk counters
   localparam logic [2:0] QR_STEP  = 3'd2;  // one step along the current direction
   localparam logic [2:0] QR_ROW   = 3'd3;  // first cell of a range row
   localparam logic [2:0] QR_RNEXT = 3'd4;  // next cell of a range row

   // Ring index operations.
   localparam logic [1:0] K_HOLD = 2'd0;
   localparam logic [1:0] K_ONE  = 2'd1;
   localparam logic [1:0] K_INC  = 2'd2;

   // Range row offset operations.
   localparam logic [1:0] DQ_HOLD = 2'd0;
   localparam logic [1:0] DQ_INIT = 2'd1;
   localparam logic [1:0] DQ_INC  = 2'd2;

   // Selection of the last flag of an emitted cell.
   localparam logic [2:0] L_NONE   = 3'd0;
   localparam logic [2:0] L_ALWAYS = 3'd1;
   localparam logic [2:0] L_NZERO  = 3'd2;
   localparam logic [2:0] L_RING   = 3'd3;
   localparam logic [2:0] L_RANGE  = 3'd4;

   // Jump conditions; when false the program falls through to the next word.
   localparam logic [2:0] C_NONE         = 3'd0;
   localparam logic [2:0] C_ALWAYS       = 3'd1;
   localparam logic [2:0] C_KZERO        = 3'd2;
   localparam logic [2:0] C_NZERO        = 3'd3;
   localparam logic [2:0] C_NOT_RING_END = 3'd4;
   localparam logic [2:0] C_KLTN         = 3'd5;
   localparam logic [2:0] C_DRLTHI       = 3'd6;
   localparam logic [2:0] C_DQLTN        = 3'd7;

   // Microprogram addresses.
   localparam logic [PC_W-1:0] A_IDLE      = 4'd0;
   localparam logic [PC_W-1:0] A_RING_INIT = 4'd1;
   localparam logic [PC_W-1:0] A_RING_WALK = 4'd2;
   localparam logic [PC_W-1:0] A_RING_END  = 4'd3;
   localparam logic [PC_W-1:0] A_RING_ZERO = 4'd4;
   localparam logic [PC_W-1:0] A_SP_CENTER = 4'd5;
   localparam logic [PC_W-1:0] A_SP_INIT   = 4'd6;
   localparam logic [PC_W-1:0] A_SP_WALK   = 4'd7;
   localparam logic [PC_W-1:0] A_SP_NEXT   = 4'd8;
   localparam logic [PC_W-1:0] A_SP_END    = 4'd9;
   localparam logic [PC_W-1:0] A_RG_INIT   = 4'd10;
   localparam logic [PC_W-1:0] A_RG_ROW    = 4'd11;
   localparam logic [PC_W-1:0] A_RG_WALK   = 4'd12;
   localparam logic [PC_W-1:0] A_RG_NEXT   = 4'd13;
   localparam logic [PC_W-1:0] A_RG_END    = 4'd14;

   typedef struct packed {
      logic            emit;
      logic [2:0]      qr_op;
      logic [1:0]      k_op;
      logic [1:0]      dq_op;
      logic [2:0]      last_sel;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic ring_end;
      logic k_zero;
      logic n_zero;
      logic k_lt_n;
      logic dr_lt_hi;
      logic dq_lt_n;
   } status_type;

   // Unit step in q for each of the six directions.
   function automatic logic signed [CW-1:0] dir_dq(input logic [RAD_W-1:0] dir);
      logic signed [CW-1:0] d;
      case (dir)
         3'd0, 3'd1: d = CW'(1);
         3'd3, 3'd4: d = -CW'(1);
         default:    d = '0;
      endcase
      return d;
   endfunction

   // Unit step in r for each of the six directions.
   function automatic logic signed [CW-1:0] dir_dr(input logic [RAD_W-1:0] dir);
      logic signed [CW-1:0] d;
      case (dir)
         3'd1, 3'd2: d = -CW'(1);
         3'd4, 3'd5: d = CW'(1);
         default:    d = '0;
      endcase
      return d;
   endfunction

endpackage

### design/hex_region_enumerator.sv
// Top level of the hex region enumerator: microcode store, step counter and
// coordinate datapath. Depends on hre_pkg, hre_ucode_rom, hre_sequencer, hre_datapath.
//
//   channel    handshake          payload
//   request    start / busy       req_action, req_center_q, req_center_r, req_radius
//   response   rsp_valid strobe   rsp_cell_q, rsp_cell_r, rsp_cell_s, rsp_last
//
// A request is taken at a rising edge with start high and busy low. Cells come out
// one per cycle while a self-looping walk word runs, one such word per region kind;
// the radius is saturated at 4. Action 3 is taken and dropped.
// Reset is synchronous and clears the step counter and the response strobe; no
// stall exists on the response side, each cell is shown for exactly one cycle.
module hex_region_enumerator
   import hre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_action,
   input  logic signed [IN_W-1:0] req_center_q,
   input  logic signed [IN_W-1:0] req_center_r,
   input  logic [RAD_W-1:0]       req_radius,
   output logic                   rsp_valid,
   output logic signed [CW-1:0]   rsp_cell_q,
   output logic signed [CW-1:0]   rsp_cell_r,
   output logic signed [CW-1:0]   rsp_cell_s,
   output logic                   rsp_last
);

   logic [PC_W-1:0] pc;
   ctrl_word_type   ctrl;
   status_type      status;
   logic            accept;

   // The request is taken only while the program sits at its idle word.
   assign accept = start && !busy;

   // The control word is read straight from the step counter; each word drives
   // the datapath and chooses the next step.
   hre_ucode_rom u_rom (
      .addr (pc),
      .word (ctrl)
   );

   hre_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .ctrl   (ctrl),
      .status (status),
      .pc     (pc),
      .busy   (busy)
   );

   // The datapath loads the center on a taken request and otherwise follows the
   // control word; emitted cells are registered before they reach the ports.
   hre_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .center_q   (req_center_q),
      .center_r   (req_center_r),
      .radius     (req_radius),
      .ctrl       (ctrl),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_cell_q (rsp_cell_q),
      .rsp_cell_r (rsp_cell_r),
      .rsp_cell_s (rsp_cell_s),
      .rsp_last   (rsp_last)
   );

endmodule

### design/hre_ucode_rom.sv
// Microprogram store of the hex region enumerator: one control word per address.
// Depends on hre_pkg.
module hre_ucode_rom
   import hre_pkg::*;
(
   input  logic [PC_W-1:0] addr,
   output ctrl_word_type   word
);

   always_comb begin
      word = '{emit: 1'b0, qr_op: QR_HOLD, k_op: K_HOLD, dq_op: DQ_HOLD,
               last_sel: L_NONE, cond: C_NONE, target: A_IDLE};
      case (addr)
         A_IDLE: begin
            word.cond = C_NONE;
         end
         // Ring: corner cell, then the six sides.
         A_RING_INIT: begin
            word.qr_op  = QR_RING;
            word.cond   = C_KZERO;
            word.target = A_RING_ZERO;
         end
         A_RING_WALK: begin
            word.emit     = 1'b1;
            word.qr_op    = QR_STEP;
            word.last_sel = L_RING;
            word.cond     = C_NOT_RING_END;
            word.target   = A_RING_WALK;
         end
         A_RING_END: begin
            word.cond   = C_ALWAYS;
            word.target = A_IDLE;
         end
         A_RING_ZERO: begin
            word.emit     = 1'b1;
            word.last_sel = L_ALWAYS;
            word.cond     = C_ALWAYS;
            word.target   = A_IDLE;
         end
         // Spiral: center, then rings one through the radius.
         A_SP_CENTER: begin
            word.emit     = 1'b1;
            word.k_op     = K_ONE;
            word.last_sel = L_NZERO;
            word.cond     = C_NZERO;
            word.target   = A_IDLE;
         end
         A_SP_INIT: begin
            word.qr_op = QR_RING;
         end
         A_SP_WALK: begin
            word.emit     = 1'b1;
            word.qr_op    = QR_STEP;
            word.last_sel = L_RING;
            word.cond     = C_NOT_RING_END;
            word.target   = A_SP_WALK;
         end
         A_SP_NEXT: begin
            word.k_op   = K_INC;
            word.cond   = C_KLTN;
            word.target = A_SP_INIT;
         end
         A_SP_END: begin
            word.cond   = C_ALWAYS;
            word.target = A_IDLE;
         end
         // Filled range: rows of constant q, each walked in r.
         A_RG_INIT: begin
            word.dq_op = DQ_INIT;
         end
         A_RG_ROW: begin
            word.qr_op = QR_ROW;
         end
         A_RG_WALK: begin
            word.emit     = 1'b1;
            word.qr_op    = QR_RNEXT;
            word.last_sel = L_RANGE;
            word.cond     = C_DRLTHI;
            word.target   = A_RG_WALK;
         end
         A_RG_NEXT: begin
            word.dq_op  = DQ_INC;
            word.cond   = C_DQLTN;
            word.target = A_RG_ROW;
         end
         A_RG_END: begin
            word.cond   = C_ALWAYS;
            word.target = A_IDLE;
         end
         default: begin
            word.cond   = C_ALWAYS;
            word.target = A_IDLE;
         end
      endcase
   end

endmodule

### design/hre_sequencer.sv
// Step counter of the hex region enumerator: dispatch on a new request and
// conditional jumps taken from the control word. Depends on hre_pkg.
module hre_sequencer
   import hre_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      action,
   input  ctrl_word_type   ctrl,
   input  status_type      status,
   output logic [PC_W-1:0] pc,
   output logic            busy
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic [PC_W-1:0] entry;
   logic            take;

   always_comb begin
      case (action)
         ACT_RING:   entry = A_RING_INIT;
         ACT_RANGE:  entry = A_RG_INIT;
         ACT_SPIRAL: entry = A_SP_CENTER;
         default:    entry = A_IDLE;
      endcase
   end

   always_comb begin
      case (ctrl.cond)
         C_NONE:         take = 1'b0;
         C_ALWAYS:       take = 1'b1;
         C_KZERO:        take = status.k_zero;
         C_NZERO:        take = status.n_zero;
         C_NOT_RING_END: take = !status.ring_end;
         C_KLTN:         take = status.k_lt_n;
         C_DRLTHI:       take = status.dr_lt_hi;
         C_DQLTN:        take = status.dq_lt_n;
         default:        take = 1'b0;
      endcase
   end

   always_comb begin
      if (pc_ff == A_IDLE) begin
         pc_in = start ? entry : A_IDLE;
      end else if (take) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign pc   = pc_ff;
   assign busy = (pc_ff != A_IDLE);

`ifndef ASSERT_OFF
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == A_IDLE && !start) |=> (pc_ff == A_IDLE))
      else $error("sequencer left idle without a request");
   a_request_starts: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == A_IDLE && start && action != ACT_UNUSED) |=> busy)
      else $error("accepted request did not start the program");
`endif

endmodule

### design/hre_datapath.sv
// Coordinate datapath of the hex region enumerator: center, current cell,
// ring and range counters, and the registered result port. Depends on hre_pkg.
module hre_datapath
   import hre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic signed [IN_W-1:0] center_q,
   input  logic signed [IN_W-1:0] center_r,
   input  logic [RAD_W-1:0]       radius,
   input  ctrl_word_type          ctrl,
   output status_type             status,
   output logic                   rsp_valid,
   output logic signed [CW-1:0]   rsp_cell_q,
   output logic signed [CW-1:0]   rsp_cell_r,
   output logic signed [CW-1:0]   rsp_cell_s,
   output logic                   rsp_last
);

   logic signed [CW-1:0]    cq_ff, cq_in, cr_ff, cr_in;
   logic signed [CW-1:0]    q_ff, q_in, r_ff, r_in;
   logic [RAD_W-1:0]        n_ff, n_in, k_ff, k_in;
   logic [RAD_W-1:0]        dir_ff, dir_in, j_ff, j_in;
   logic signed [OFS_W-1:0] dq_ff, dq_in, dr_ff, dr_in, hi_ff, hi_in;
   logic signed [OFS_W-1:0] nn, lo_val, hi_val;
   logic [RAD_W-1:0]        nsat, k_m1;
   logic                    side_end, last;
   logic                    rsp_valid_ff;
   logic signed [CW-1:0]    cell_q_ff, cell_r_ff, cell_s_ff;
   logic                    last_ff;

   assign nsat   = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
   assign nn     = OFS_W'(n_ff);
   assign k_m1   = k_ff - RAD_W'(1);
   // A row left of center is cut at the bottom, one right of center at the top.
   assign lo_val = (dq_ff < 0) ? (-dq_ff - nn) : -nn;
   assign hi_val = (dq_ff > 0) ? (-dq_ff + nn) : nn;
   assign side_end = (j_ff == k_m1);

   assign status.ring_end = side_end && (dir_ff == RAD_W'(5));
   assign status.k_zero   = (k_ff == '0);
   assign status.n_zero   = (n_ff == '0);
   assign status.k_lt_n   = (k_ff < n_ff);
   assign status.dr_lt_hi = (dr_ff < hi_ff);
   assign status.dq_lt_n  = (dq_ff < nn);

   always_comb begin
      case (ctrl.last_sel)
         L_NONE:   last = 1'b0;
         L_ALWAYS: last = 1'b1;
         L_NZERO:  last = status.n_zero;
         L_RING:   last = status.ring_end && (k_ff == n_ff);
         L_RANGE:  last = !status.dr_lt_hi && !status.dq_lt_n;
         default:  last = 1'b0;
      endcase
   end

   always_comb begin
      cq_in  = cq_ff;
      cr_in  = cr_ff;
      n_in   = n_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      dir_in = dir_ff;
      j_in   = j_ff;
      dr_in  = dr_ff;
      hi_in  = hi_ff;
      if (accept) begin
         // A new request loads the center; the current cell starts there too.
         cq_in = {center_q[IN_W-1], center_q};
         cr_in = {center_r[IN_W-1], center_r};
         n_in  = nsat;
         q_in  = {center_q[IN_W-1], center_q};
         r_in  = {center_r[IN_W-1], center_r};
      end else begin
         case (ctrl.qr_op)
            QR_RING: begin
               q_in   = cq_ff - CW'(k_ff);
               r_in   = cr_ff + CW'(k_ff);
               dir_in = '0;
               j_in   = '0;
            end
            QR_STEP: begin
               q_in = q_ff + dir_dq(dir_ff);
               r_in = r_ff + dir_dr(dir_ff);
               if (side_end) begin
                  j_in   = '0;
                  dir_in = dir_ff + RAD_W'(1);
               end else begin
                  j_in = j_ff + RAD_W'(1);
               end
            end
            QR_ROW: begin
               q_in  = cq_ff + {{(CW-OFS_W){dq_ff[OFS_W-1]}}, dq_ff};
               r_in  = cr_ff + {{(CW-OFS_W){lo_val[OFS_W-1]}}, lo_val};
               dr_in = lo_val;
               hi_in = hi_val;
            end
            QR_RNEXT: begin
               r_in  = r_ff + CW'(1);
               dr_in = dr_ff + OFS_W'(1);
            end
            default: begin
               q_in = q_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         k_in = nsat;
      end else begin
         case (ctrl.k_op)
            K_ONE:   k_in = RAD_W'(1);
            K_INC:   k_in = k_ff + RAD_W'(1);
            default: k_in = k_ff;
         endcase
      end
   end

   always_comb begin
      case (ctrl.dq_op)
         DQ_INIT: dq_in = -nn;
         DQ_INC:  dq_in = dq_ff + OFS_W'(1);
         default: dq_in = dq_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      cq_ff  <= cq_in;
      cr_ff  <= cr_in;
      n_ff   <= n_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      dir_ff <= dir_in;
      j_ff   <= j_in;
      dq_ff  <= dq_in;
      dr_ff  <= dr_in;
      hi_ff  <= hi_in;
      if (ctrl.emit) begin
         cell_q_ff <= q_ff;
         cell_r_ff <= r_ff;
         cell_s_ff <= -q_ff - r_ff;
         last_ff   <= last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cell_q = cell_q_ff;
   assign rsp_cell_r = cell_r_ff;
   assign rsp_cell_s = cell_s_ff;
   assign rsp_last   = last_ff;

`ifndef ASSERT_OFF
   a_cube_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((cell_q_ff + cell_r_ff + cell_s_ff) == CW'(0)))
      else $error("emitted cell breaks q + r + s = 0");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |=> !rsp_valid_ff)
      else $error("cell emitted right after the last cell of a region");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for hex_region_enumerator: directed and random region requests,
// cell-by-cell comparison against an in-bench enumerator of ring, range and spiral regions.
// Depends on hre_pkg and the hex_region_enumerator RTL.
module tb
   import hre_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off here. The slowest correct run is about 410 requests, none
   // longer than a radius 4 range, plus sender gaps, so this leaves a wide margin.
   localparam int CYCLE_LIMIT = 400000;
   // Cycles to watch for stray cells once nothing more is expected; a radius 4
   // range is the longest walk.
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_PER_PHASE = 87;

   typedef struct {
      logic [1:0]             action;
      logic signed [IN_W-1:0] cq;
      logic signed [IN_W-1:0] cr;
      logic [RAD_W-1:0]       radius;
      int                     idle_pct;   // chance in percent that the sender holds off at an edge where it could send
   } region_request_type;

   typedef struct {
      logic signed [CW-1:0] q;
      logic signed [CW-1:0] r;
      logic signed [CW-1:0] s;
      logic                 last;
   } hex_cell_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_action = ACT_RING;
   logic signed [IN_W-1:0] req_center_q = '0;
   logic signed [IN_W-1:0] req_center_r = '0;
   logic [RAD_W-1:0]       req_radius = '0;
   logic                   rsp_valid;
   logic signed [CW-1:0]   rsp_cell_q;
   logic signed [CW-1:0]   rsp_cell_r;
   logic signed [CW-1:0]   rsp_cell_s;
   logic                   rsp_last;

   region_request_type pending_requests[$];   // requests waiting to be offered
   hex_cell_type       expected_cells[$];     // cells the block still owes, oldest first
   region_request_type offered;               // request currently on the req_ ports
   int                 total_requests = 0;
   int                 requests_taken = 0;
   int                 mismatches = 0;
   int                 cycle_count = 0;

   hex_region_enumerator u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_center_q (req_center_q),
      .req_center_r (req_center_r),
      .req_radius   (req_radius),
      .rsp_valid    (rsp_valid),
      .rsp_cell_q   (rsp_cell_q),
      .rsp_cell_r   (rsp_cell_r),
      .rsp_cell_s   (rsp_cell_s),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   // Unit steps of the six hex directions, in walking order.
   function automatic int hex_step_q(input int dir);
      case (dir)
         0, 1:    return 1;
         3, 4:    return -1;
         default: return 0;
      endcase
   endfunction

   function automatic int hex_step_r(input int dir);
      case (dir)
         1, 2:    return -1;
         4, 5:    return 1;
         default: return 0;
      endcase
   endfunction

   // Coordinates are computed exactly in 32 bits and wrapped to the 16-bit ports.
   // Only s can actually wrap, when q + r sits near the 15-bit extremes.
   task automatic add_cell(input int q, input int r);
      int           s;
      hex_cell_type hc;
      s = -q - r;
      hc.q = q[CW-1:0];
      hc.r = r[CW-1:0];
      hc.s = s[CW-1:0];
      hc.last = 1'b0;
      expected_cells.push_back(hc);
   endtask

   // A ring starts radius steps out along the southwest direction and walks
   // radius steps along each direction, emitting each cell before stepping off.
   task automatic add_ring(input int cq, input int cr, input int n);
      int q;
      int r;
      q = cq - n;
      r = cr + n;
      if (n == 0) begin
         add_cell(cq, cr);
      end else begin
         for (int dir = 0; dir < 6; dir++) begin
            for (int j = 0; j < n; j++) begin
               add_cell(q, r);
               q += hex_step_q(dir);
               r += hex_step_r(dir);
            end
         end
      end
   endtask

   // Appends every cell that one accepted request produces, flagging the final one.
   task automatic enumerate_region(input region_request_type req);
      int           cq;
      int           cr;
      int           n;
      int           lo;
      int           hi;
      int           size_prior;
      hex_cell_type tail;
      cq = int'(req.cq);
      cr = int'(req.cr);
      n = int'(req.radius);
      if (n > MAX_RADIUS) n = MAX_RADIUS;
      size_prior = expected_cells.size();
      case (req.action)
         ACT_RING: begin
            add_ring(cq, cr, n);
         end
         ACT_RANGE: begin
            // Filled hexagon, q-major: each column dq spans the r offsets that
            // keep the cell within n steps of the center.
            for (int dq = -n; dq <= n; dq++) begin
               lo = (-dq - n > -n) ? -dq - n : -n;
               hi = (-dq + n < n) ? -dq + n : n;
               for (int dr = lo; dr <= hi; dr++) add_cell(cq + dq, cr + dr);
            end
         end
         ACT_SPIRAL: begin
            add_cell(cq, cr);
            for (int k = 1; k <= n; k++) add_ring(cq, cr, k);
         end
         default: begin
            // The unused action code is accepted and yields nothing.
         end
      endcase
      if (expected_cells.size() > size_prior) begin
         tail = expected_cells.pop_back();
         tail.last = 1'b1;
         expected_cells.push_back(tail);
      end
   endtask

   task automatic queue_request(input logic [1:0] action, input int q, input int r,
                                input int radius, input int idle_pct);
      region_request_type req;
      req.action = action;
      req.cq = q[IN_W-1:0];
      req.cr = r[IN_W-1:0];
      req.radius = radius[RAD_W-1:0];
      req.idle_pct = idle_pct;
      pending_requests.push_back(req);
      total_requests++;
   endtask

   // Random center coordinate: either fully random bits, a value close to one of
   // the 15-bit extremes, or a small value near the origin.
   function automatic int random_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? -16384 + int'($urandom_range(0, 5))
                                              : 16383 - int'($urandom_range(0, 5));
         1:       return int'($urandom_range(0, 40)) - 20;
         default: return int'($urandom);
      endcase
   endfunction

   // Driver. A request counts as taken at an edge where start was high and busy
   // low; the expected cells are worked out right there. When the slot is free
   // the next request goes out unless the sender chooses to idle this cycle.
   // start is assigned at most once per edge so a back-to-back request keeps it high.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            enumerate_region(offered);
            requests_taken++;
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= pending_requests[0].idle_pct) begin
               offered = pending_requests.pop_front();
               req_action <= offered.action;
               req_center_q <= offered.cq;
               req_center_r <= offered.cr;
               req_radius <= offered.radius;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. The block cannot be held off, so every strobed cell is taken at
   // the edge that ends its cycle and compared with the oldest expected cell.
   always @(posedge clock) begin
      hex_cell_type want;
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            $display("%0t: cell (%0d, %0d, %0d) last %0b arrived with none expected",
                     $time, rsp_cell_q, rsp_cell_r, rsp_cell_s, rsp_last);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_cell_q !== want.q) begin
               $display("%0t: cell_q expected %0d, got %0d", $time, want.q, rsp_cell_q);
               mismatches++;
            end
            if (rsp_cell_r !== want.r) begin
               $display("%0t: cell_r expected %0d, got %0d", $time, want.r, rsp_cell_r);
               mismatches++;
            end
            if (rsp_cell_s !== want.s) begin
               $display("%0t: cell_s expected %0d, got %0d", $time, want.s, rsp_cell_s);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hex_region_enumerator verification failed");
         $finish;
      end
   end

   initial begin
      int phase_idle[4];
      int valid_count;
      int action_pick;
      logic [1:0] action;

      // Directed requests: each region kind at radius zero, one, the maximum and
      // above it (which saturates), the dropped action code, and centers at the
      // 15-bit extremes where s wraps around in 16 bits.
      queue_request(ACT_RING, 0, 0, 0, 0);
      queue_request(ACT_RING, 0, 0, 1, 0);
      queue_request(ACT_RING, 5, -3, 4, 0);
      queue_request(ACT_RING, -2, 7, 7, 0);
      queue_request(ACT_RANGE, 3, 3, 0, 0);
      queue_request(ACT_RANGE, 0, 0, 1, 0);
      queue_request(ACT_RANGE, -9, 1, 4, 0);
      queue_request(ACT_RANGE, 1, -1, 6, 0);
      queue_request(ACT_SPIRAL, -1, -1, 0, 0);
      queue_request(ACT_SPIRAL, 0, 0, 1, 0);
      queue_request(ACT_SPIRAL, 4, 0, 2, 0);
      queue_request(ACT_SPIRAL, 0, 0, 4, 0);
      queue_request(ACT_SPIRAL, 2, -6, 5, 0);
      queue_request(ACT_UNUSED, 1, 2, 2, 0);
      queue_request(ACT_UNUSED, 0, 0, 0, 0);
      queue_request(ACT_RING, -16384, -16384, 4, 0);
      queue_request(ACT_RANGE, 16383, 16383, 4, 0);
      queue_request(ACT_SPIRAL, -16384, 16383, 4, 0);
      queue_request(ACT_RANGE, 16383, -16384, 3, 0);
      queue_request(ACT_RING, -16384, 0, 2, 0);
      queue_request(ACT_SPIRAL, -16384, -16384, 4, 0);
      queue_request(ACT_RANGE, -16384, -16383, 7, 0);

      // Random phases: back to back, a sender idle most of the time, a sender
      // idle now and then, and a final stretch with no gaps at all.
      phase_idle = '{0, 66, 6, 0};
      foreach (phase_idle[p]) begin
         valid_count = 0;
         while (valid_count < RANDOM_PER_PHASE) begin
            action_pick = $urandom_range(0, 19);
            if (action_pick < 6) action = ACT_RING;
            else if (action_pick < 12) action = ACT_RANGE;
            else if (action_pick < 18) action = ACT_SPIRAL;
            else action = ACT_UNUSED;
            if (action != ACT_UNUSED) valid_count++;
            queue_request(action, random_coord(), random_coord(),
                          $urandom_range(0, 7), phase_idle[p]);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every cell to arrive, then keep
      // watching a while for cells that nobody asked for.
      while (requests_taken != total_requests) @(negedge clock);
      while (expected_cells.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("hex_region_enumerator verification clean");
      end else begin
         $display("hex_region_enumerator verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
design/hre_pkg.sv
design/hre_ucode_rom.sv
design/hre_sequencer.sv
design/hre_datapath.sv
design/hex_region_enumerator.sv
tb/tb.sv
